>>> rtl/core/imu_sct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sct_pkg
// shared widths, reset values, register codes and lane types for the imu
// sample calibrate and track block
// ----------------------------------------------------------------------------
package imu_sct_pkg;

    localparam int AXES       = 6;
    localparam int GYRO_AXES  = 3;
    localparam int WINDOW     = 5;

    localparam int RAW_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int OFFS_W     = 24;
    localparam int VAL_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int AXIS_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // raw times gain, one spare bit for the unsigned gain
    localparam int PROD_W     = RAW_W + GAIN_W + 1;
    localparam int FRAC_SH    = 8;

    // history window
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int SUM_W      = VAL_W + SLOT_W;

    // mean by reciprocal multiply: floor(n / WINDOW) = (n * REC_M) >> REC_S
    // exact for any magnitude below 2^SUM_W
    localparam int REC_L      = $clog2(WINDOW);
    localparam int REC_S      = SUM_W + REC_L;
    localparam int REC_W      = SUM_W + 1;
    localparam logic [63:0] REC_M64 =
        ((64'd1 << REC_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [REC_W-1:0] REC_M = REC_M64[REC_W-1:0];
    localparam int MAG_LO_W   = (SUM_W + 1) / 2;
    localparam int MAG_HI_W   = SUM_W - MAG_LO_W;
    localparam int REC_LO_W   = (REC_W + 1) / 2;
    localparam int REC_HI_W   = REC_W - REC_LO_W;
    localparam int PP_W       = SUM_W + REC_W;

    // stages from input to lane result
    localparam int LAT        = 8;

    localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 24'd73400;
    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 24'd10040;
    localparam logic signed [OFFS_W-1:0] OFFS_RST [AXES] = '{
        24'sd20787, -24'sd16343, 24'sd15626,
        -24'sd1373, -24'sd11059, -24'sd5883
    };

    localparam logic signed [VAL_W-1:0] PEAK_HIGH_RST = -32'sd13107200;
    localparam logic signed [VAL_W-1:0] PEAK_LOW_RST  = 32'sd13107200;
    localparam logic signed [VAL_W-1:0] VAL_MAX       = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN       = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GYRO_GAIN,
        REG_ACCEL_GAIN,
        REG_GYRO_X_OFFS,
        REG_GYRO_Y_OFFS,
        REG_GYRO_Z_OFFS,
        REG_ACCEL_X_OFFS,
        REG_ACCEL_Y_OFFS,
        REG_ACCEL_Z_OFFS
    } cfg_idx_t;

    typedef struct packed {
        logic              adv;
        logic              upd;
        logic [SLOT_W-1:0] slot;
    } lane_ctrl_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] cal;
        logic signed [VAL_W-1:0] pk_max;
        logic signed [VAL_W-1:0] pk_min;
        logic signed [VAL_W-1:0] mean;
    } lane_res_t;

endpackage
`default_nettype wire

>>> rtl/core/imu_sct_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sct_in_if
// sample channel: six raw axis readings and a millisecond stamp per item
// ----------------------------------------------------------------------------
interface imu_sct_in_if;
    import imu_sct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [RAW_W-1:0]  gyro_x_raw;
    logic signed [RAW_W-1:0]  gyro_y_raw;
    logic signed [RAW_W-1:0]  gyro_z_raw;
    logic signed [RAW_W-1:0]  accel_x_raw;
    logic signed [RAW_W-1:0]  accel_y_raw;
    logic signed [RAW_W-1:0]  accel_z_raw;
    logic [STAMP_W-1:0]       stamp_ms;

    modport source (
        output valid, gyro_x_raw, gyro_y_raw, gyro_z_raw,
               accel_x_raw, accel_y_raw, accel_z_raw, stamp_ms,
        input  ready
    );

    modport sink (
        input  valid, gyro_x_raw, gyro_y_raw, gyro_z_raw,
               accel_x_raw, accel_y_raw, accel_z_raw, stamp_ms,
        output ready
    );

endinterface
`default_nettype wire

>>> rtl/core/imu_sct_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sct_out_if
// result channel: one calibrated axis with peaks, window mean and stamp
// ----------------------------------------------------------------------------
interface imu_sct_out_if;
    import imu_sct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [AXIS_W-1:0]        axis;
    logic signed [VAL_W-1:0]  calibrated;
    logic signed [VAL_W-1:0]  peak_max;
    logic signed [VAL_W-1:0]  peak_min;
    logic signed [VAL_W-1:0]  window_mean;
    logic [STAMP_W-1:0]       window_stamp;
    logic                     last;

    modport source (
        output valid, axis, calibrated, peak_max, peak_min,
               window_mean, window_stamp, last,
        input  ready
    );

    modport sink (
        input  valid, axis, calibrated, peak_max, peak_min,
               window_mean, window_stamp, last,
        output ready
    );

endinterface
`default_nettype wire

>>> rtl/core/imu_sct_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sct_lane
// one axis: gain and offset calibration, peak tracking, history window with
// running sum, and window mean by reciprocal multiply
// ----------------------------------------------------------------------------
module imu_sct_lane (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  imu_sct_pkg::lane_ctrl_t                ctrl,
    input  logic signed [imu_sct_pkg::RAW_W-1:0]   raw,
    input  logic [imu_sct_pkg::GAIN_W-1:0]         gain,
    input  logic signed [imu_sct_pkg::OFFS_W-1:0]  offset,
    output imu_sct_pkg::lane_res_t                 res
);
    import imu_sct_pkg::*;

    localparam int SH_W  = PROD_W - FRAC_SH;
    localparam int CAL_W = SH_W + 1;
    localparam int TRIO_N = LAT - 2;
    localparam int NEG_N  = 4;

    typedef struct packed {
        logic signed [VAL_W-1:0] cal;
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] lo;
    } trio_t;

    logic signed [GAIN_W:0]      gain_s;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_reg;

    logic signed [SH_W-1:0]      shifted;
    logic signed [CAL_W-1:0]     cal_wide;
    logic                        ovf;
    logic signed [VAL_W-1:0]     cal_next;
    logic signed [VAL_W-1:0]     cal2_reg;

    logic signed [VAL_W-1:0]     hist_reg [WINDOW];
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [VAL_W-1:0]     hi_reg;
    logic signed [VAL_W-1:0]     lo_reg;
    logic signed [VAL_W-1:0]     old_val;
    logic signed [SUM_W-1:0]     sum_next;
    logic signed [VAL_W-1:0]     hi_next;
    logic signed [VAL_W-1:0]     lo_next;

    logic signed [SUM_W-1:0]     sum3_reg;
    trio_t                       trio_reg [TRIO_N];
    logic                        neg_reg [NEG_N];
    logic [SUM_W-1:0]            mag_next;
    logic [SUM_W-1:0]            mag4_reg;

    logic [MAG_LO_W-1:0]         mag_lo;
    logic [MAG_HI_W-1:0]         mag_hi;
    logic [REC_LO_W-1:0]         rec_lo;
    logic [REC_HI_W-1:0]         rec_hi;
    logic [MAG_LO_W+REC_LO_W-1:0] pp_ll_reg;
    logic [MAG_LO_W+REC_HI_W-1:0] pp_lh_reg;
    logic [MAG_HI_W+REC_LO_W-1:0] pp_hl_reg;
    logic [MAG_HI_W+REC_HI_W-1:0] pp_hh_reg;

    logic [PP_W-1:0]             ta_next;
    logic [PP_W-1:0]             tb_next;
    logic [PP_W-1:0]             ta6_reg;
    logic [PP_W-1:0]             tb6_reg;
    logic [PP_W-1:0]             total;
    logic [VAL_W-1:0]            q7_reg;
    logic signed [VAL_W-1:0]     mean8_reg;

    // scale
    assign gain_s    = {1'b0, gain};
    assign prod_next = raw * gain_s;

    // floor shift, offset, saturate
    assign shifted  = prod_reg[PROD_W-1:FRAC_SH];
    assign cal_wide = CAL_W'(shifted) + CAL_W'(offset);
    assign ovf      = (cal_wide[CAL_W-1:VAL_W-1] != {(CAL_W-VAL_W+1){cal_wide[CAL_W-1]}});
    assign cal_next = ovf ? (cal_wide[CAL_W-1] ? VAL_MIN : VAL_MAX) : cal_wide[VAL_W-1:0];

    // tracking against the stored state
    assign old_val  = hist_reg[ctrl.slot];
    assign sum_next = sum_reg + SUM_W'(cal2_reg) - SUM_W'(old_val);
    assign hi_next  = (cal2_reg > hi_reg) ? cal2_reg : hi_reg;
    assign lo_next  = (cal2_reg < lo_reg) ? cal2_reg : lo_reg;

    // mean datapath
    assign mag_next = SUM_W'(-sum3_reg);
    assign mag_lo   = mag4_reg[MAG_LO_W-1:0];
    assign mag_hi   = mag4_reg[SUM_W-1:MAG_LO_W];
    assign rec_lo   = REC_M[REC_LO_W-1:0];
    assign rec_hi   = REC_M[REC_W-1:REC_LO_W];
    assign ta_next  = PP_W'(pp_ll_reg) + (PP_W'(pp_lh_reg) << REC_LO_W);
    assign tb_next  = (PP_W'(pp_hl_reg) << MAG_LO_W)
                    + (PP_W'(pp_hh_reg) << (MAG_LO_W + REC_LO_W));
    assign total    = ta6_reg + tb6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
            sum_reg <= '0;
            hi_reg  <= PEAK_HIGH_RST;
            lo_reg  <= PEAK_LOW_RST;
        end
        else if (ctrl.upd)
        begin
            hist_reg[ctrl.slot] <= cal2_reg;
            sum_reg <= sum_next;
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            prod_reg    <= prod_next;
            cal2_reg    <= cal_next;
            sum3_reg    <= sum_next;
            trio_reg[0] <= '{cal: cal2_reg, hi: hi_next, lo: lo_next};
            for (int i = 1; i < TRIO_N; i++)
            begin
                trio_reg[i] <= trio_reg[i-1];
            end
            neg_reg[0]  <= sum3_reg[SUM_W-1];
            for (int i = 1; i < NEG_N; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
            mag4_reg    <= sum3_reg[SUM_W-1] ? mag_next : SUM_W'(sum3_reg);
            pp_ll_reg   <= mag_lo * rec_lo;
            pp_lh_reg   <= mag_lo * rec_hi;
            pp_hl_reg   <= mag_hi * rec_lo;
            pp_hh_reg   <= mag_hi * rec_hi;
            ta6_reg     <= ta_next;
            tb6_reg     <= tb_next;
            q7_reg      <= total[REC_S +: VAL_W];
            mean8_reg   <= neg_reg[NEG_N-1] ? -q7_reg : q7_reg;
        end
    end

    assign res = '{
        cal:    trio_reg[TRIO_N-1].cal,
        pk_max: trio_reg[TRIO_N-1].hi,
        pk_min: trio_reg[TRIO_N-1].lo,
        mean:   mean8_reg
    };

endmodule
`default_nettype wire

>>> rtl/core/imu_sct_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sct_merge
// gathers the six lane results of an item, sends one per cycle while ready
// ----------------------------------------------------------------------------
module imu_sct_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pend,
    output logic                                taken,
    input  imu_sct_pkg::lane_res_t              lane_res [imu_sct_pkg::AXES],
    input  logic [imu_sct_pkg::STAMP_W-1:0]     stamp,
    imu_sct_out_if.source                       result
);
    import imu_sct_pkg::*;

    lane_res_t          bank_reg [AXES];
    logic [STAMP_W-1:0] bstamp_reg;
    logic               bvalid_reg;
    logic [AXIS_W-1:0]  idx_reg;
    logic               take;
    logic               is_last;
    logic               free;

    assign take    = bvalid_reg && result.ready;
    assign is_last = (idx_reg == AXIS_W'(AXES - 1));
    assign free    = !bvalid_reg || (take && is_last);
    assign taken   = pend && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (taken)
        begin
            bvalid_reg <= 1'b1;
            idx_reg    <= '0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                bvalid_reg <= 1'b0;
                idx_reg    <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken)
        begin
            bank_reg   <= lane_res;
            bstamp_reg <= stamp;
        end
    end

    assign result.valid        = bvalid_reg;
    assign result.axis         = idx_reg;
    assign result.calibrated   = bank_reg[idx_reg].cal;
    assign result.peak_max     = bank_reg[idx_reg].pk_max;
    assign result.peak_min     = bank_reg[idx_reg].pk_min;
    assign result.window_mean  = bank_reg[idx_reg].mean;
    assign result.window_stamp = bstamp_reg;
    assign result.last         = is_last;

endmodule
`default_nettype wire

>>> rtl/core/imu_sample_calibrate_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sample_calibrate_track
// six-axis sample calibration with per-axis peak and window-mean tracking
// ----------------------------------------------------------------------------
// flow: the lane stages carry an item into the merge bank, and the result
//   port offers axis 0 first, then axes 1..5 one per cycle while ready
// throughput: the result port moves one axis per cycle out of the merge
//   bank while ready; the lanes accept an item per cycle unless stalled
// reset: registers to their default gains and offsets, peaks to +/-200.0,
//   history, running sums, slot and window stamp to zero; no clearing pass
// ----------------------------------------------------------------------------
module imu_sample_calibrate_track (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [imu_sct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imu_sct_pkg::CFG_DATA_W-1:0]     cfg_data,
    imu_sct_in_if.sink                             sample,
    imu_sct_out_if.source                          result
);
    import imu_sct_pkg::*;

    // stage index where peaks, history and window slot are updated
    localparam int ST_TRACK = 2;

    // configuration registers
    logic [GAIN_W-1:0]          gyro_gain_reg;
    logic [GAIN_W-1:0]          accel_gain_reg;
    logic signed [OFFS_W-1:0]   offset_reg [AXES];

    // pipeline control, shared by all lanes
    logic                       valid_reg [LAT];
    logic [STAMP_W-1:0]         stamp_reg [LAT];
    logic [SLOT_W-1:0]          write_slot_reg;
    logic [STAMP_W-1:0]         done_stamp_reg;
    logic [STAMP_W-1:0]         done_stamp_next;
    logic                       wrap;
    logic                       adv;
    logic                       upd;
    logic                       taken;
    lane_ctrl_t                 lane_ctrl;

    logic signed [RAW_W-1:0]    raw_arr [AXES];
    lane_res_t                  lane_res [AXES];

    // register writes only while idle: a user rule, not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_gain_reg  <= GYRO_GAIN_RST;
            accel_gain_reg <= ACCEL_GAIN_RST;
            for (int i = 0; i < AXES; i++)
            begin
                offset_reg[i] <= OFFS_RST[i];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_GYRO_GAIN:    gyro_gain_reg  <= cfg_data;
                REG_ACCEL_GAIN:   accel_gain_reg <= cfg_data;
                REG_GYRO_X_OFFS:  offset_reg[0]  <= cfg_data;
                REG_GYRO_Y_OFFS:  offset_reg[1]  <= cfg_data;
                REG_GYRO_Z_OFFS:  offset_reg[2]  <= cfg_data;
                REG_ACCEL_X_OFFS: offset_reg[3]  <= cfg_data;
                REG_ACCEL_Y_OFFS: offset_reg[4]  <= cfg_data;
                REG_ACCEL_Z_OFFS: offset_reg[5]  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // whole pipeline moves unless the last stage waits for the merge bank
    assign adv          = !valid_reg[LAT-1] || taken;
    assign sample.ready = adv;
    assign upd          = adv && valid_reg[ST_TRACK-1];

    // window wrap records the stamp of the item that fills the last slot
    assign wrap            = (write_slot_reg == SLOT_W'(WINDOW - 1));
    assign done_stamp_next = (upd && wrap) ? stamp_reg[ST_TRACK-1] : done_stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            write_slot_reg <= '0;
            done_stamp_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                valid_reg[0] <= sample.valid;
                for (int i = 1; i < LAT; i++)
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
            if (upd)
            begin
                write_slot_reg <= wrap ? '0 : write_slot_reg + 1'b1;
                done_stamp_reg <= done_stamp_next;
            end
        end
    end

    // stamp of each item travels beside it; from the track stage on it is
    // the stamp of the last completed window
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stamp_reg[0] <= sample.stamp_ms;
            for (int i = 1; i < LAT; i++)
            begin
                if (i == ST_TRACK)
                begin
                    stamp_reg[i] <= done_stamp_next;
                end
                else
                begin
                    stamp_reg[i] <= stamp_reg[i-1];
                end
            end
        end
    end

    assign lane_ctrl = '{adv: adv, upd: upd, slot: write_slot_reg};

    assign raw_arr[0] = sample.gyro_x_raw;
    assign raw_arr[1] = sample.gyro_y_raw;
    assign raw_arr[2] = sample.gyro_z_raw;
    assign raw_arr[3] = sample.accel_x_raw;
    assign raw_arr[4] = sample.accel_y_raw;
    assign raw_arr[5] = sample.accel_z_raw;

    // one lane per axis; gyro axes share one gain, accel axes the other
    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        imu_sct_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .raw    (raw_arr[a]),
            .gain   ((a < GYRO_AXES) ? gyro_gain_reg : accel_gain_reg),
            .offset (offset_reg[a]),
            .res    (lane_res[a])
        );
    end

    // serializes the six lane results into axis order
    imu_sct_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .pend     (valid_reg[LAT-1]),
        .taken    (taken),
        .lane_res (lane_res),
        .stamp    (stamp_reg[LAT-1]),
        .result   (result)
    );

endmodule
`default_nettype wire

>>> tb/imu_sample_calibrate_track_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_sample_calibrate_track_tb
// drives six-axis samples through the calibrate and track block under changing
// gains and offsets, random sample gaps, random result stalls, and checks every
// axis result against an in-bench model of scaling, peaks and window mean
// ----------------------------------------------------------------------------
module imu_sample_calibrate_track_tb;
    import imu_sct_pkg::*;

    // no-progress limit, well above the deliberate result hold-off
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 65;

    typedef enum {
        PACE_TX38_RX61,
        PACE_TX61_RX38,
        PACE_NO_IDLE
    } pace_t;

    typedef struct {
        logic signed [RAW_W-1:0] raw [AXES];
        logic [STAMP_W-1:0]      stamp;
    } imu_sample_t;

    typedef struct packed {
        logic [AXIS_W-1:0]       axis;
        logic signed [VAL_W-1:0] cal;
        logic signed [VAL_W-1:0] pk_max;
        logic signed [VAL_W-1:0] pk_min;
        logic signed [VAL_W-1:0] mean;
        logic [STAMP_W-1:0]      stamp;
        logic                    last;
    } axis_result_t;

    typedef logic [CFG_DATA_W-1:0] offs_set_t [AXES];

    // calibration and per-axis tracking model plus the queue of axis results
    // still owed by the block
    class calib_track_checker;
        logic [GAIN_W-1:0]        gain [2];
        logic signed [OFFS_W-1:0] offs [AXES];
        logic signed [VAL_W-1:0]  peak_hi [AXES];
        logic signed [VAL_W-1:0]  peak_lo [AXES];
        logic signed [VAL_W-1:0]  hist [AXES][WINDOW];
        int                       slot;
        logic [STAMP_W-1:0]       wrap_stamp;
        axis_result_t             pending_axes [$];
        int                       mismatches;

        function new();
            gain[0] = 24'd73400;
            gain[1] = 24'd10040;
            offs[0] = 24'sd20787;
            offs[1] = -24'sd16343;
            offs[2] = 24'sd15626;
            offs[3] = -24'sd1373;
            offs[4] = -24'sd11059;
            offs[5] = -24'sd5883;
            for (int a = 0; a < AXES; a++)
            begin
                peak_hi[a] = -32'sd13107200;
                peak_lo[a] = 32'sd13107200;
                for (int k = 0; k < WINDOW; k++)
                    hist[a][k] = '0;
            end
            slot = 0;
            wrap_stamp = '0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GYRO_GAIN:  gain[0] = data;
                REG_ACCEL_GAIN: gain[1] = data;
                default:        offs[int'(idx) - int'(REG_GYRO_X_OFFS)] = data;
            endcase
        endfunction

        function logic signed [VAL_W-1:0] scale_axis(logic signed [RAW_W-1:0] raw,
                                                     logic [GAIN_W-1:0] g,
                                                     logic signed [OFFS_W-1:0] off);
            longint prod;
            longint total;
            longint hi_lim;
            longint lo_lim;
            hi_lim = 64'sd2147483647;
            lo_lim = -64'sd2147483648;
            prod = longint'(raw) * longint'(g);
            total = (prod >>> 8) + longint'(off);
            if (total > hi_lim)
                total = hi_lim;
            if (total < lo_lim)
                total = lo_lim;
            return total[VAL_W-1:0];
        endfunction

        function void note_sample(imu_sample_t s);
            logic signed [VAL_W-1:0] cal [AXES];
            longint acc;
            axis_result_t r;
            int cur;
            cur = slot;
            for (int a = 0; a < AXES; a++)
            begin
                cal[a] = scale_axis(s.raw[a], gain[a < GYRO_AXES ? 0 : 1], offs[a]);
                if (cal[a] > peak_hi[a])
                    peak_hi[a] = cal[a];
                if (cal[a] < peak_lo[a])
                    peak_lo[a] = cal[a];
                hist[a][cur] = cal[a];
            end
            if (cur == WINDOW - 1)
            begin
                wrap_stamp = s.stamp;
                slot = 0;
            end
            else
                slot = cur + 1;
            for (int a = 0; a < AXES; a++)
            begin
                acc = 0;
                for (int k = 0; k < WINDOW; k++)
                    acc += longint'(hist[a][k]);
                acc = acc / WINDOW;
                r.axis = AXIS_W'(a);
                r.cal = cal[a];
                r.pk_max = peak_hi[a];
                r.pk_min = peak_lo[a];
                r.mean = acc[VAL_W-1:0];
                r.stamp = wrap_stamp;
                r.last = (a == AXES - 1);
                pending_axes.push_back(r);
            end
        endfunction

        function void check_axis(axis_result_t got);
            axis_result_t want;
            if (pending_axes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: axis=%0d cal=%0d", got.axis, got.cal);
                return;
            end
            want = pending_axes.pop_front();
            if (got.axis !== want.axis || got.cal !== want.cal ||
                got.pk_max !== want.pk_max || got.pk_min !== want.pk_min ||
                got.mean !== want.mean || got.stamp !== want.stamp ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch");
                    $display("exp: axis=%0d cal=%0d max=%0d min=%0d mean=%0d stamp=%0h last=%0b",
                             want.axis, want.cal, want.pk_max, want.pk_min, want.mean,
                             want.stamp, want.last);
                    $display("got: axis=%0d cal=%0d max=%0d min=%0d mean=%0d stamp=%0h last=%0b",
                             got.axis, got.cal, got.pk_max, got.pk_min, got.mean,
                             got.stamp, got.last);
                end
            end
        endfunction

        function int outstanding();
            return pending_axes.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    imu_sct_in_if  sample_if ();
    imu_sct_out_if result_if ();

    imu_sample_calibrate_track u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_if),
        .result    (result_if)
    );

    calib_track_checker track;
    pace_t              pace;
    int                 hold_request;
    imu_sample_t        prev_sample;
    bit                 have_prev;

    // free-running clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // idle odds per cycle for each side under the current pacing
    function automatic int tx_idle_pct();
        case (pace)
            PACE_TX38_RX61: return 38;
            PACE_TX61_RX38: return 61;
            default:        return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct();
        case (pace)
            PACE_TX38_RX61: return 61;
            PACE_TX61_RX38: return 38;
            default:        return 0;
        endcase
    endfunction

    // same reading on every axis, used for the corner values
    function automatic imu_sample_t flat_sample(logic signed [RAW_W-1:0] v,
                                                logic [STAMP_W-1:0] stamp);
        imu_sample_t s;
        for (int a = 0; a < AXES; a++)
            s.raw[a] = v;
        s.stamp = stamp;
        return s;
    endfunction

    // random readings, leaning on full-scale, zero and minus one
    function automatic imu_sample_t random_sample();
        imu_sample_t s;
        for (int a = 0; a < AXES; a++)
        begin
            case ($urandom_range(9))
                0:       s.raw[a] = 16'sh7fff;
                1:       s.raw[a] = 16'sh8000;
                2:       s.raw[a] = '0;
                3:       s.raw[a] = '1;
                default: s.raw[a] = RAW_W'($urandom);
            endcase
        end
        s.stamp = $urandom;
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_gain();
        case ($urandom_range(3))
            0:       return '1;
            1:       return CFG_DATA_W'($urandom_range(200000));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // offer one item, hold it until taken, then maybe leave a gap
    task automatic send_sample(input imu_sample_t s);
        int gap;
        sample_if.valid       <= 1'b1;
        sample_if.gyro_x_raw  <= s.raw[0];
        sample_if.gyro_y_raw  <= s.raw[1];
        sample_if.gyro_z_raw  <= s.raw[2];
        sample_if.accel_x_raw <= s.raw[3];
        sample_if.accel_y_raw <= s.raw[4];
        sample_if.accel_z_raw <= s.raw[5];
        sample_if.stamp_ms    <= s.stamp;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        track.note_sample(s);
        prev_sample = s;
        have_prev = 1'b1;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < tx_idle_pct())
            gap++;
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // random items, now and then a repeat of the last one so equal values
    // hit the peak compare
    task automatic send_random(input int count);
        imu_sample_t s;
        for (int n = 0; n < count; n++)
        begin
            if (have_prev && $urandom_range(15) == 0)
            begin
                s = prev_sample;
                s.stamp = $urandom;
            end
            else
                s = random_sample();
            send_sample(s);
        end
    endtask

    // sender goes quiet until every owed axis result has come back
    task automatic drain();
        sample_if.valid <= 1'b0;
        while (track.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        track.set_reg(idx, data);
        @(posedge clk);
    endtask

    // whole register set, written back to back while the block is idle
    task automatic load_config(input logic [CFG_DATA_W-1:0] gyro_g,
                               input logic [CFG_DATA_W-1:0] accel_g,
                               input offs_set_t offs);
        write_reg(REG_GYRO_GAIN, gyro_g);
        write_reg(REG_ACCEL_GAIN, accel_g);
        write_reg(REG_GYRO_X_OFFS, offs[0]);
        write_reg(REG_GYRO_Y_OFFS, offs[1]);
        write_reg(REG_GYRO_Z_OFFS, offs[2]);
        write_reg(REG_ACCEL_X_OFFS, offs[3]);
        write_reg(REG_ACCEL_Y_OFFS, offs[4]);
        write_reg(REG_ACCEL_Z_OFFS, offs[5]);
        cfg_we <= 1'b0;
    endtask

    task automatic load_random_config();
        offs_set_t offs;
        for (int a = 0; a < AXES; a++)
        begin
            case ($urandom_range(5))
                0:       offs[a] = 24'h7fffff;
                1:       offs[a] = 24'h800000;
                default: offs[a] = CFG_DATA_W'($urandom);
            endcase
        end
        load_config(random_gain(), random_gain(), offs);
    endtask

    // result side: random ready, or a long hold-off when asked for one
    initial
    begin : result_sink
        int hold_left;
        axis_result_t got;
        hold_left = 0;
        forever
        begin
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
                result_if.ready <= ($urandom_range(99) >= rx_idle_pct());
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                got.axis   = result_if.axis;
                got.cal    = result_if.calibrated;
                got.pk_max = result_if.peak_max;
                got.pk_min = result_if.peak_min;
                got.mean   = result_if.window_mean;
                got.stamp  = result_if.window_stamp;
                got.last   = result_if.last;
                track.check_axis(got);
            end
        end
    end

    // no-progress watchdog: counts cycles in which neither channel moves
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("imu_sample_calibrate_track_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        logic signed [RAW_W-1:0] corners [7];
        offs_set_t offs;
        imu_sample_t s;

        corners = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                    16'sh5555, 16'shaaaa};
        track = new();
        have_prev = 1'b0;
        hold_request = 0;
        pace = PACE_TX38_RX61;

        // every block input known from time zero
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_GYRO_GAIN;
        cfg_data              = '0;
        sample_if.valid       = 1'b0;
        sample_if.gyro_x_raw  = '0;
        sample_if.gyro_y_raw  = '0;
        sample_if.gyro_z_raw  = '0;
        sample_if.accel_x_raw = '0;
        sample_if.accel_y_raw = '0;
        sample_if.accel_z_raw = '0;
        sample_if.stamp_ms    = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains and offsets: corner readings while the window is still
        // partly zero, stamps at both ends, then a repeated item so equal
        // values leave the peaks alone
        send_sample(flat_sample(corners[2], 32'h0000_0000));
        send_sample(flat_sample(corners[0], 32'hffff_ffff));
        for (int i = 1; i < 7; i++)
            send_sample(flat_sample(corners[i], $urandom));
        s.raw = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh4000};
        s.stamp = 32'h8000_0000;
        send_sample(s);
        send_sample(s);
        send_random(RANDOM_ITEMS);
        drain();

        // full-scale gains with extreme offsets: saturation both ways, and
        // min reading/offset pairs that stay in range
        offs = '{24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000};
        load_config(24'hffffff, 24'hffffff, offs);
        for (int i = 0; i < 7; i++)
            send_sample(flat_sample(corners[i], $urandom));
        send_sample(flat_sample(corners[1], $urandom));
        send_random(RANDOM_ITEMS);
        drain();

        // pacing flips: sender slow, receiver mostly ready
        pace = PACE_TX61_RX38;

        // zero gains, so every axis reads back its offset
        for (int a = 0; a < AXES; a++)
            offs[a] = CFG_DATA_W'($urandom);
        load_config(24'h000000, 24'h000000, offs);
        send_random(RANDOM_ITEMS);
        drain();

        load_random_config();
        send_random(RANDOM_ITEMS);
        drain();

        // no idling; results held off long enough that the block backs up
        // and stalls the sample side while items keep being offered
        pace = PACE_NO_IDLE;
        load_random_config();
        hold_request = HOLD_CYCLES;
        send_random(RANDOM_ITEMS);
        drain();

        load_random_config();
        send_random(RANDOM_ITEMS);
        drain();

        // let any stray extra result show up before the verdict
        repeat (LAT + 8) @(posedge clk);
        if (track.mismatches == 0 && track.outstanding() == 0)
            $display("imu_sample_calibrate_track_tb: done, clean");
        else
            $display("imu_sample_calibrate_track_tb: done, errors");
        $finish;
    end

endmodule
